>>> sv/h2r_pkg.sv
`timescale 1ns / 1ps

package h2r_pkg;

    localparam int unsigned CH_W = 8;

    localparam logic [2:0] SEC_RG = 3'd0;
    localparam logic [2:0] SEC_GR = 3'd1;
    localparam logic [2:0] SEC_GB = 3'd2;
    localparam logic [2:0] SEC_BG = 3'd3;
    localparam logic [2:0] SEC_BR = 3'd4;
    localparam logic [2:0] SEC_RB = 3'd5;

    localparam logic [7:0] HUE_SPAN   = 8'd85;
    localparam logic [7:0] HUE_SPAN2  = 8'd170;
    localparam logic [7:0] HUE_LIM_1  = 8'd42;
    localparam logic [7:0] HUE_LIM_3  = 8'd127;
    localparam logic [7:0] HUE_LIM_5  = 8'd212;

    localparam int unsigned  XQ_SHIFT = 38;
    localparam logic [23:0]  XQ_RECIP = 24'd12681796;

    typedef struct packed {
        logic            vld;
        logic [2:0]      sector;
        logic [6:0]      k;
        logic [CH_W-1:0] sat;
        logic [CH_W-1:0] nsat;
        logic [CH_W-1:0] val;
        logic            last;
    } st1_t;

    typedef struct packed {
        logic            vld;
        logic [2:0]      sector;
        logic [14:0]     w;
        logic [15:0]     mnum;
        logic [CH_W-1:0] val;
        logic            last;
    } st2_t;

    typedef struct packed {
        logic            vld;
        logic [2:0]      sector;
        logic [22:0]     xnum;
        logic [CH_W-1:0] m;
        logic [CH_W-1:0] val;
        logic            last;
    } st3_t;

    typedef struct packed {
        logic            vld;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            last;
    } pix_t;

endpackage

>>> sv/h2r_sector.sv
`timescale 1ns / 1ps

module h2r_sector
    import h2r_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_vld,
    input  logic [CH_W-1:0] hue,
    input  logic [CH_W-1:0] sat,
    input  logic [CH_W-1:0] val,
    input  logic            last,
    output st1_t            st1
);

    st1_t       st1_reg;
    st1_t       st1_next;
    logic [7:0] rem;
    logic [7:0] dbl;
    logic [7:0] fold;

    always_comb begin
        if (hue < HUE_SPAN) begin
            rem = hue;
        end else if (hue < HUE_SPAN2) begin
            rem = hue - HUE_SPAN;
        end else begin
            rem = hue - HUE_SPAN2;
        end
        dbl  = {rem[6:0], 1'b0};
        fold = (dbl >= HUE_SPAN) ? (dbl - HUE_SPAN) : (HUE_SPAN - dbl);

        st1_next.vld  = in_vld;
        st1_next.k    = 7'(HUE_SPAN - fold);
        st1_next.sat  = sat;
        st1_next.nsat = ~sat;
        st1_next.val  = val;
        st1_next.last = last;
        priority if (hue < HUE_LIM_1) begin
            st1_next.sector = SEC_RG;
        end else if (hue < HUE_SPAN) begin
            st1_next.sector = SEC_GR;
        end else if (hue < HUE_LIM_3) begin
            st1_next.sector = SEC_GB;
        end else if (hue < HUE_SPAN2) begin
            st1_next.sector = SEC_BG;
        end else if (hue < HUE_LIM_5) begin
            st1_next.sector = SEC_BR;
        end else begin
            st1_next.sector = SEC_RB;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_reg.vld <= 1'b0;
        end else if (en) begin
            st1_reg.vld <= st1_next.vld;
        end
        if (en) begin
            st1_reg.sector <= st1_next.sector;
            st1_reg.k      <= st1_next.k;
            st1_reg.sat    <= st1_next.sat;
            st1_reg.nsat   <= st1_next.nsat;
            st1_reg.val    <= st1_next.val;
            st1_reg.last   <= st1_next.last;
        end
    end

    assign st1 = st1_reg;

endmodule

>>> sv/h2r_chroma.sv
`timescale 1ns / 1ps

module h2r_chroma
    import h2r_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic en,
    input  st1_t st1,
    output st3_t st3
);

    st2_t        st2_reg;
    st2_t        st2_next;
    st3_t        st3_reg;
    st3_t        st3_next;
    logic [16:0] mdiv;

    always_comb begin
        st2_next.vld    = st1.vld;
        st2_next.sector = st1.sector;
        st2_next.w      = 15'(st1.sat) * 15'(st1.k) + 15'(st1.nsat) * 15'(HUE_SPAN);
        st2_next.mnum   = 16'(st1.val) * 16'(st1.nsat);
        st2_next.val    = st1.val;
        st2_next.last   = st1.last;
    end

    always_comb begin
        mdiv = 17'(st2_reg.mnum) + 17'(st2_reg.mnum[15:8]) + 17'd1;
        st3_next.vld    = st2_reg.vld;
        st3_next.sector = st2_reg.sector;
        st3_next.xnum   = 23'(st2_reg.val) * 23'(st2_reg.w);
        st3_next.m      = mdiv[15:8];
        st3_next.val    = st2_reg.val;
        st3_next.last   = st2_reg.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st2_reg.vld <= 1'b0;
            st3_reg.vld <= 1'b0;
        end else if (en) begin
            st2_reg.vld <= st2_next.vld;
            st3_reg.vld <= st3_next.vld;
        end
        if (en) begin
            st2_reg.sector <= st2_next.sector;
            st2_reg.w      <= st2_next.w;
            st2_reg.mnum   <= st2_next.mnum;
            st2_reg.val    <= st2_next.val;
            st2_reg.last   <= st2_next.last;
            st3_reg.sector <= st3_next.sector;
            st3_reg.xnum   <= st3_next.xnum;
            st3_reg.m      <= st3_next.m;
            st3_reg.val    <= st3_next.val;
            st3_reg.last   <= st3_next.last;
        end
    end

    assign st3 = st3_reg;

endmodule

>>> sv/h2r_output.sv
`timescale 1ns / 1ps

module h2r_output
    import h2r_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic en,
    input  st3_t st3,
    output pix_t pix
);

    pix_t            pix_reg;
    pix_t            pix_next;
    logic [46:0]     prod;
    logic [CH_W-1:0] xm;

    always_comb begin
        prod = 47'(st3.xnum) * 47'(XQ_RECIP);
        xm   = prod[XQ_SHIFT +: CH_W];
        pix_next.vld  = st3.vld;
        pix_next.last = st3.last;
        unique case (st3.sector)
            SEC_RG: begin
                pix_next.red   = st3.val;
                pix_next.green = xm;
                pix_next.blue  = st3.m;
            end
            SEC_GR: begin
                pix_next.red   = xm;
                pix_next.green = st3.val;
                pix_next.blue  = st3.m;
            end
            SEC_GB: begin
                pix_next.red   = st3.m;
                pix_next.green = st3.val;
                pix_next.blue  = xm;
            end
            SEC_BG: begin
                pix_next.red   = st3.m;
                pix_next.green = xm;
                pix_next.blue  = st3.val;
            end
            SEC_BR: begin
                pix_next.red   = xm;
                pix_next.green = st3.m;
                pix_next.blue  = st3.val;
            end
            default: begin
                pix_next.red   = st3.val;
                pix_next.green = st3.m;
                pix_next.blue  = xm;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pix_reg.vld <= 1'b0;
        end else if (en) begin
            pix_reg.vld <= pix_next.vld;
        end
        if (en) begin
            pix_reg.red   <= pix_next.red;
            pix_reg.green <= pix_next.green;
            pix_reg.blue  <= pix_next.blue;
            pix_reg.last  <= pix_next.last;
        end
    end

    assign pix = pix_reg;

endmodule

>>> sv/hsv_to_rgb_8bit_top.sv
`timescale 1ns / 1ps

// Converts one 8-bit HSV pixel to one 8-bit RGB pixel per transaction, with
// exact integer arithmetic and every component truncated toward zero. The
// block takes a new pixel in every cycle unless the output is stalled, and
// passes each pixel through four register stages (sector decode, chroma
// products, secondary product, reciprocal division and channel select)
// that move together and hold as a whole while the output is stalled. The
// line-end flag travels from s_axis_tlast to m_axis_tlast with its pixel.

module hsv_to_rgb_8bit_top
    import h2r_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // hue [7:0], saturation [15:8], brightness [23:16]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
    output logic        m_axis_tlast
);

    logic pipe_en;
    st1_t st1;
    st3_t st3;
    pix_t pix;

    assign pipe_en       = m_axis_tready || !pix.vld;
    assign s_axis_tready = pipe_en;

    h2r_sector u_sector (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (pipe_en),
        .in_vld  (s_axis_tvalid),
        .hue     (s_axis_tdata[7:0]),
        .sat     (s_axis_tdata[15:8]),
        .val     (s_axis_tdata[23:16]),
        .last    (s_axis_tlast),
        .st1     (st1)
    );

    h2r_chroma u_chroma (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (pipe_en),
        .st1     (st1),
        .st3     (st3)
    );

    h2r_output u_output (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (pipe_en),
        .st3     (st3),
        .pix     (pix)
    );

    assign m_axis_tvalid = pix.vld;
    assign m_axis_tdata  = {pix.blue, pix.green, pix.red};
    assign m_axis_tlast  = pix.last;

    a_ready_follows_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready == (m_axis_tready || !m_axis_tvalid))
        else $error("input ready does not follow the output stage");

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_last_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (st3.vld && pipe_en) |=> m_axis_tvalid)
        else $error("pixel lost between last stage and output");

    a_stall_keeps_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output changed");

endmodule

>>> sim/hsv_pixel_checker.sv
`timescale 1ns / 1ps

module hsv_pixel_checker
    import h2r_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    output int          mismatch_count,
    output int          pixels_pending
);

    localparam int unsigned SECTOR_SPAN = 85;
    localparam int unsigned X_DENOM     = 21675;
    localparam int unsigned M_DENOM     = 255;
    localparam int unsigned FULL_SCALE  = 255;
    localparam int unsigned LIMIT_GR    = 42;
    localparam int unsigned LIMIT_GB    = 85;
    localparam int unsigned LIMIT_BG    = 127;
    localparam int unsigned LIMIT_BR    = 170;
    localparam int unsigned LIMIT_RB    = 212;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            line_end;
    } rgb_pixel_t;

    rgb_pixel_t  rgb_expected_q[$];
    int          pixels_in  = 0;
    int          pixels_out = 0;

    initial mismatch_count = 0;

    assign pixels_pending = pixels_in - pixels_out;

    function automatic rgb_pixel_t hsv_to_rgb(input logic [CH_W-1:0] hue,
                                              input logic [CH_W-1:0] sat,
                                              input logic [CH_W-1:0] bri,
                                              input logic            line_end);
        int unsigned h;
        int unsigned s;
        int unsigned v;
        int unsigned twice_rem;
        int unsigned fold;
        int unsigned ramp;
        int unsigned top;
        int unsigned mid;
        int unsigned low;
        rgb_pixel_t  pix;
        h = hue;
        s = sat;
        v = bri;
        twice_rem = 2 * (h % SECTOR_SPAN);
        fold = (twice_rem >= SECTOR_SPAN) ? twice_rem - SECTOR_SPAN
                                          : SECTOR_SPAN - twice_rem;
        ramp = SECTOR_SPAN - fold;
        top = v;
        mid = (v * s * ramp + v * (FULL_SCALE - s) * SECTOR_SPAN) / X_DENOM;
        low = (v * (FULL_SCALE - s)) / M_DENOM;
        if (h < LIMIT_GR) begin
            pix.red = top[7:0]; pix.green = mid[7:0]; pix.blue = low[7:0];
        end else if (h < LIMIT_GB) begin
            pix.red = mid[7:0]; pix.green = top[7:0]; pix.blue = low[7:0];
        end else if (h < LIMIT_BG) begin
            pix.red = low[7:0]; pix.green = top[7:0]; pix.blue = mid[7:0];
        end else if (h < LIMIT_BR) begin
            pix.red = low[7:0]; pix.green = mid[7:0]; pix.blue = top[7:0];
        end else if (h < LIMIT_RB) begin
            pix.red = mid[7:0]; pix.green = low[7:0]; pix.blue = top[7:0];
        end else begin
            pix.red = top[7:0]; pix.green = low[7:0]; pix.blue = mid[7:0];
        end
        pix.line_end = line_end;
        return pix;
    endfunction

    always @(posedge aclk) begin
        rgb_pixel_t want;
        rgb_pixel_t got;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                rgb_expected_q.push_back(hsv_to_rgb(s_axis_tdata[7:0], s_axis_tdata[15:8],
                                                    s_axis_tdata[23:16], s_axis_tlast));
                pixels_in <= pixels_in + 1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
                       m_axis_tlast};
                if (rgb_expected_q.size() == 0) begin
                    $display("%0t: unexpected transaction, got rgb %0d %0d %0d last %0b",
                             $time, got.red, got.green, got.blue, got.line_end);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    want = rgb_expected_q.pop_front();
                    pixels_out <= pixels_out + 1;
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue || got.line_end !== want.line_end) begin
                        $display("%0t: mismatch, expected %0d %0d %0d %0b, got %0d %0d %0d %0b",
                                 $time, want.red, want.green, want.blue, want.line_end,
                                 got.red, got.green, got.blue, got.line_end);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
        end
    end

endmodule

>>> sim/tb_hsv_to_rgb_8bit_top.sv
`timescale 1ns / 1ps

module tb_hsv_to_rgb_8bit_top;

    localparam int RANDOM_PIXELS = 1650;
    localparam int HOLD_CYCLES   = 400;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;

    int          mismatch_count;
    int          pixels_pending;
    int          idle_pct  = 0;
    int          stall_pct = 0;
    logic        hold_req  = 1'b0;
    logic        hold_done = 1'b0;
    int          hold_left = 0;

    always #4 aclk = ~aclk;

    hsv_to_rgb_8bit_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    hsv_pixel_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tlast   (s_axis_tlast),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast),
        .mismatch_count (mismatch_count),
        .pixels_pending (pixels_pending)
    );

    // The receiver holds off once for a long stretch so the pipeline fills up.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_axis_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic send_pixel(input logic [7:0] hue, input logic [7:0] sat,
                              input logic [7:0] bri, input logic line_end);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {bri, sat, hue};
        s_axis_tlast  <= line_end;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_level();
        int unsigned roll;
        roll = $urandom_range(0, 15);
        if (roll == 0) return 8'd0;
        if (roll == 1) return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_hue();
        logic [7:0] hue_marks[6];
        hue_marks = '{8'd0, 8'd42, 8'd85, 8'd127, 8'd170, 8'd212};
        if ($urandom_range(0, 7) == 0) begin
            return 8'(hue_marks[$urandom_range(0, 5)] + $urandom_range(0, 2) - 1);
        end
        return 8'($urandom_range(0, 255));
    endfunction

    initial begin
        logic [7:0] hue_marks[15];
        int         idle_phase[4];
        int         stall_phase[4];
        hue_marks   = '{8'd41, 8'd42, 8'd43, 8'd84, 8'd85, 8'd86, 8'd126, 8'd127,
                        8'd128, 8'd169, 8'd170, 8'd171, 8'd211, 8'd212, 8'd213};
        idle_phase  = '{0, 50, 0, 20};
        stall_phase = '{0, 0, 50, 20};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
        send_pixel(8'd0, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd128, 8'd0, 8'd255, 1'b0);
        send_pixel(8'd200, 8'd255, 8'd0, 1'b1);
        send_pixel(8'd42, 8'd100, 8'd250, 1'b0);
        send_pixel(8'd212, 8'd77, 8'd199, 1'b0);
        send_pixel(8'd85, 8'd1, 8'd254, 1'b1);
        for (int i = 0; i < 15; i++) begin
            send_pixel(hue_marks[i], 8'd255, 8'd255, i == 14);
        end

        for (int phase = 0; phase < 4; phase++) begin
            idle_pct  <= idle_phase[phase];
            stall_pct <= stall_phase[phase];
            for (int n = 0; n < RANDOM_PIXELS / 4; n++) begin
                if (phase == 0 && n == 100) hold_req <= 1'b1;
                send_pixel(pick_hue(), pick_level(), pick_level(),
                           $urandom_range(0, 7) == 0);
            end
        end
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);

        while (pixels_pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && pixels_pending == 0) begin
            $display("tb_hsv_to_rgb_8bit_top passed");
        end else begin
            $display("tb_hsv_to_rgb_8bit_top failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb_hsv_to_rgb_8bit_top failed");
        $finish;
    end

endmodule
